>>> hw/rtl/generational_handle_allocator_unit_defines.svh
// assertion macros used by the checker file gha_checker.sv
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define GHA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gha_pkg.sv
package gha_pkg;

  localparam int ENTRIES_DEF = 1024;
  localparam int ROUNDS_DEF  = 1024;

  localparam int ACTION_W    = 2;
  localparam int ID_IN_W     = 31;
  localparam int TYPE_W      = 8;
  localparam int INDEX_W     = 20;
  localparam int OBJ_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int OUT_ID_W    = 20;
  localparam int USED_W      = 11;
  localparam int ROUND_CFG_W = 10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_RETAG   = 2'd2,
    ACT_LOOKUP  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_BAD_ID  = 2'd2
  } status_t;

endpackage

>>> hw/rtl/gha_if.sv
interface gha_in_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::ACTION_W-1:0]  action;
  logic [gha_pkg::ID_IN_W-1:0]   id;
  logic [gha_pkg::TYPE_W-1:0]    obj_type;
  logic [gha_pkg::INDEX_W-1:0]   obj_index;
  logic [gha_pkg::OBJ_W-1:0]     obj_handle;

  modport source (output valid, action, id, obj_type, obj_index, obj_handle, input ready);
  modport sink (input valid, action, id, obj_type, obj_index, obj_handle, output ready);
endinterface

interface gha_out_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::STATUS_W-1:0]  status;
  logic [gha_pkg::OUT_ID_W-1:0]  out_id;
  logic [gha_pkg::TYPE_W-1:0]    out_type;
  logic [gha_pkg::INDEX_W-1:0]   out_index;
  logic [gha_pkg::OBJ_W-1:0]     out_object;
  logic [gha_pkg::USED_W-1:0]    used_count;

  modport source (output valid, status, out_id, out_type, out_index, out_object, used_count,
                  input ready);
  modport sink (input valid, status, out_id, out_type, out_index, out_object, used_count,
                output ready);
endinterface

>>> hw/rtl/generational_handle_allocator_unit.sv
// Handle allocator: hands out ids slot + round * ENTRIES from a free-slot FIFO and checks
// ids on release, retag and lookup against a slot table; one result per request, in order.
// After reset the block sweeps both memories, one entry per cycle, before in_req.ready
// first rises (cfg writes are taken during the sweep). With a power-of-two ENTRIES a
// request first does the synchronous read of the slot table and FIFO, then updates
// them and loads the result register; otherwise the slot number comes from a registered
// constant-divide pipeline first. A write of cfg_wr_data is reduced modulo ROUNDS by the
// same kind of unit; unless ROUNDS is a power of two or above 1023 this holds off new
// requests until the reduced round is loaded.
module generational_handle_allocator_unit #(
  parameter int ENTRIES = gha_pkg::ENTRIES_DEF,
  parameter int ROUNDS  = gha_pkg::ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [gha_pkg::ROUND_CFG_W-1:0]   cfg_wr_data,
  gha_in_if.sink                            in_req,
  gha_out_if.source                         out_rsp
);

  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int ROUND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ID_W    = $clog2(longint'(ENTRIES) * longint'(ROUNDS));
  localparam int IDIN_W  = gha_pkg::ID_IN_W;
  localparam int OID_W   = gha_pkg::OUT_ID_W;
  localparam int USE_W   = gha_pkg::USED_W;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DIV, S_EXEC} state_t;

  typedef struct packed {
    logic                         valid;
    logic [ID_W-1:0]              id;
    logic [gha_pkg::TYPE_W-1:0]   otype;
    logic [gha_pkg::INDEX_W-1:0]  oindex;
    logic [gha_pkg::OBJ_W-1:0]    obj;
  } slot_t;

  state_t                       state_r, state_nxt;
  logic [SLOT_W-1:0]            clr_addr_r, clr_addr_nxt;
  gha_pkg::action_t             req_action_r, req_action_nxt;
  logic [IDIN_W-1:0]            req_id_r, req_id_nxt;
  logic [gha_pkg::TYPE_W-1:0]   req_type_r, req_type_nxt;
  logic [gha_pkg::INDEX_W-1:0]  req_index_r, req_index_nxt;
  logic [gha_pkg::OBJ_W-1:0]    req_obj_r, req_obj_nxt;
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [SLOT_W-1:0]            head_r, head_nxt;
  logic [SLOT_W-1:0]            tail_r, tail_nxt;
  logic [CNT_W-1:0]             fill_r, fill_nxt;
  logic [CNT_W-1:0]             used_r, used_nxt;
  logic [CNT_W-1:0]             taken_r, taken_nxt;
  logic [CNT_W-1:0]             quota_r, quota_nxt;
  logic [ROUND_W-1:0]           round_r, round_nxt;
  logic                         cfg_busy_r, cfg_busy_nxt;

  logic                         out_valid_r, out_valid_nxt;
  gha_pkg::status_t             out_status_r, out_status_nxt;
  logic [OID_W-1:0]             out_id_r, out_id_nxt;
  logic [gha_pkg::TYPE_W-1:0]   out_type_r, out_type_nxt;
  logic [gha_pkg::INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [gha_pkg::OBJ_W-1:0]    out_object_r, out_object_nxt;
  logic [USE_W-1:0]             out_used_r, out_used_nxt;

  slot_t                        slot_mem [ENTRIES];
  slot_t                        slot_rd_r;
  logic                         slot_rd_en;
  logic [SLOT_W-1:0]            slot_rd_addr;
  logic                         slot_we;
  logic [SLOT_W-1:0]            slot_wa;
  slot_t                        slot_wd;

  logic [SLOT_W-1:0]            fifo_mem [ENTRIES];
  logic [SLOT_W-1:0]            fifo_rd_r;
  logic                         fifo_we;
  logic [SLOT_W-1:0]            fifo_wa;
  logic [SLOT_W-1:0]            fifo_wd;

  logic                         in_ready;
  logic                         accept;
  logic                         id_start;
  logic                         id_done;
  logic [SLOT_W-1:0]            id_rem;
  logic                         rnd_done;
  logic [ROUND_W-1:0]           rnd_rem;

  assign in_ready     = (state_r == S_IDLE) && !cfg_busy_r && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_ready;
  assign id_start     = accept;
  assign in_req.ready = in_ready;

  gha_modc #(
    .IN_W    (IDIN_W),
    .DIVISOR (ENTRIES)
  ) u_id_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (id_start),
    .dividend (in_req.id),
    .done     (id_done),
    .rem      (id_rem)
  );

  gha_modc #(
    .IN_W    (gha_pkg::ROUND_CFG_W),
    .DIVISOR (ROUNDS)
  ) u_round_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_wr_en),
    .dividend (cfg_wr_data),
    .done     (rnd_done),
    .rem      (rnd_rem)
  );

  always_comb begin
    logic               hit;
    logic [ROUND_W-1:0] round_adv;
    logic [CNT_W-1:0]   taken_base;
    logic [ID_W-1:0]    new_id;

    hit        = slot_rd_r.valid && (IDIN_W'(slot_rd_r.id) == req_id_r);
    round_adv  = round_r;
    taken_base = taken_r;
    new_id     = ID_W'(fifo_rd_r) + ID_W'(round_r) * ID_W'(ENTRIES);

    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    req_action_nxt = req_action_r;
    req_id_nxt     = req_id_r;
    req_type_nxt   = req_type_r;
    req_index_nxt  = req_index_r;
    req_obj_nxt    = req_obj_r;
    slot_nxt       = slot_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    used_nxt       = used_r;
    taken_nxt      = taken_r;
    quota_nxt      = quota_r;
    round_nxt      = round_r;

    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_type_nxt   = out_type_r;
    out_index_nxt  = out_index_r;
    out_object_nxt = out_object_r;
    out_used_nxt   = out_used_r;

    slot_rd_en   = 1'b0;
    slot_rd_addr = id_rem;
    slot_we      = 1'b0;
    slot_wa      = slot_r;
    slot_wd      = slot_rd_r;
    fifo_we      = 1'b0;
    fifo_wa      = tail_r;
    fifo_wd      = slot_r;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_addr_r;
        slot_wd = '0;
        fifo_we = 1'b1;
        fifo_wa = clr_addr_r;
        fifo_wd = clr_addr_r;
        if (clr_addr_r == SLOT_W'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          req_action_nxt = gha_pkg::action_t'(in_req.action);
          req_id_nxt     = in_req.id;
          req_type_nxt   = in_req.obj_type;
          req_index_nxt  = in_req.obj_index;
          req_obj_nxt    = in_req.obj_handle;
          if (id_done) begin
            slot_rd_en = 1'b1;
            slot_nxt   = id_rem;
            state_nxt  = S_EXEC;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (id_done) begin
          slot_rd_en = 1'b1;
          slot_nxt   = id_rem;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = gha_pkg::STAT_OK;
        out_id_nxt     = req_id_r[OID_W-1:0];
        out_type_nxt   = '0;
        out_index_nxt  = '0;
        out_object_nxt = '0;
        state_nxt      = S_IDLE;

        case (req_action_r)
          gha_pkg::ACT_ALLOC: begin
            // charge the round quota first, even if no slot is free
            if (taken_r >= quota_r) begin
              quota_nxt  = CNT_W'(ENTRIES) - used_r;
              taken_base = '0;
              round_adv  = (round_r == ROUND_W'(ROUNDS - 1)) ? '0 : round_r + 1'b1;
            end
            taken_nxt = taken_base + 1'b1;
            round_nxt = round_adv;
            new_id    = ID_W'(fifo_rd_r) + ID_W'(round_adv) * ID_W'(ENTRIES);
            if (fill_r == '0) begin
              out_status_nxt = gha_pkg::STAT_NO_FREE;
              out_id_nxt     = '0;
            end else begin
              head_nxt       = (head_r == SLOT_W'(ENTRIES - 1)) ? '0 : head_r + 1'b1;
              fill_nxt       = fill_r - 1'b1;
              used_nxt       = used_r + 1'b1;
              slot_we        = 1'b1;
              slot_wa        = fifo_rd_r;
              slot_wd.valid  = 1'b1;
              slot_wd.id     = new_id;
              slot_wd.otype  = req_type_r;
              slot_wd.oindex = req_index_r;
              slot_wd.obj    = req_obj_r;
              out_id_nxt     = OID_W'(new_id);
            end
          end

          gha_pkg::ACT_RELEASE: begin
            if (!hit || (fill_r == CNT_W'(ENTRIES))) begin
              out_status_nxt = gha_pkg::STAT_BAD_ID;
            end else begin
              fifo_we  = 1'b1;
              fifo_wa  = tail_r;
              fifo_wd  = slot_r;
              tail_nxt = (tail_r == SLOT_W'(ENTRIES - 1)) ? '0 : tail_r + 1'b1;
              fill_nxt = fill_r + 1'b1;
              used_nxt = used_r - 1'b1;
              slot_we  = 1'b1;
              slot_wd  = '0;
            end
          end

          gha_pkg::ACT_RETAG: begin
            if (!hit) begin
              out_status_nxt = gha_pkg::STAT_BAD_ID;
            end else begin
              slot_we        = 1'b1;
              slot_wd.otype  = req_type_r;
              slot_wd.oindex = req_index_r;
            end
          end

          default: begin
            if (!hit) begin
              out_status_nxt = gha_pkg::STAT_BAD_ID;
            end else begin
              out_type_nxt   = slot_rd_r.otype;
              out_index_nxt  = slot_rd_r.oindex;
              out_object_nxt = slot_rd_r.obj;
            end
          end
        endcase

        out_used_nxt = USE_W'(used_nxt);
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (rnd_done) begin
      round_nxt = rnd_rem;
    end
    cfg_busy_nxt = (cfg_busy_r || cfg_wr_en) && !rnd_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= CNT_W'(ENTRIES);
      used_r      <= '0;
      taken_r     <= '0;
      quota_r     <= CNT_W'(ENTRIES);
      round_r     <= '0;
      cfg_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      used_r      <= used_nxt;
      taken_r     <= taken_nxt;
      quota_r     <= quota_nxt;
      round_r     <= round_nxt;
      cfg_busy_r  <= cfg_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_action_r <= req_action_nxt;
    req_id_r     <= req_id_nxt;
    req_type_r   <= req_type_nxt;
    req_index_r  <= req_index_nxt;
    req_obj_r    <= req_obj_nxt;
    slot_r       <= slot_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_type_r   <= out_type_nxt;
    out_index_r  <= out_index_nxt;
    out_object_r <= out_object_nxt;
    out_used_r   <= out_used_nxt;
  end

  // slot table
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_rd_en) begin
      slot_rd_r <= slot_mem[slot_rd_addr];
    end
  end

  // free-slot fifo, head entry read every cycle
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_wa] <= fifo_wd;
    end
    fifo_rd_r <= fifo_mem[head_r];
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.out_id     = out_id_r;
  assign out_rsp.out_type   = out_type_r;
  assign out_rsp.out_index  = out_index_r;
  assign out_rsp.out_object = out_object_r;
  assign out_rsp.used_count = out_used_r;

endmodule

>>> hw/rtl/gha_modc.sv
module gha_modc #(
  parameter int IN_W    = gha_pkg::ID_IN_W,
  parameter int DIVISOR = gha_pkg::ENTRIES_DEF,
  localparam int REM_W  = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IN_W-1:0]  dividend,
  output logic             done,
  output logic [REM_W-1:0] rem
);

  localparam bit IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);
  localparam bit DIRECT  = IS_POW2 || (longint'(DIVISOR) >= (longint'(1) << IN_W));
  localparam int EXT_W   = (IN_W > REM_W) ? IN_W : REM_W;

  if (DIRECT) begin : g_direct
    localparam logic [EXT_W-1:0] MASK = IS_POW2 ? EXT_W'(DIVISOR - 1) : {EXT_W{1'b1}};
    logic [EXT_W-1:0] din_ext;

    assign din_ext = EXT_W'(dividend);
    assign done    = start;
    assign rem     = REM_W'(din_ext & MASK);
  end else begin : g_recip
    // quotient estimate by reciprocal, low by at most one, fixed up by one subtract
    localparam int K   = IN_W + REM_W;
    localparam int M_W = IN_W + 1;
    localparam int P_W = IN_W + M_W;
    localparam logic [63:0]    RECIP64 = (64'd1 << K) / 64'(DIVISOR);
    localparam logic [M_W-1:0] RECIP   = RECIP64[M_W-1:0];

    logic             v1_r, v2_r, v3_r;
    logic [IN_W-1:0]  din1_r, din2_r;
    logic [P_W-1:0]   prod1_r;
    logic [IN_W:0]    prod2_r;
    logic [REM_W-1:0] rem_r;
    logic [IN_W:0]    diff;
    logic [IN_W:0]    fixed;

    assign diff  = {1'b0, din2_r} - prod2_r;
    assign fixed = (diff >= (IN_W + 1)'(DIVISOR)) ? diff - (IN_W + 1)'(DIVISOR) : diff;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r <= 1'b0;
        v2_r <= 1'b0;
        v3_r <= 1'b0;
      end else begin
        v1_r <= start;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        din1_r  <= dividend;
        prod1_r <= P_W'(dividend) * P_W'(RECIP);
      end
      if (v1_r) begin
        din2_r  <= din1_r;
        prod2_r <= (IN_W + 1)'(prod1_r[P_W-1:K]) * (IN_W + 1)'(DIVISOR);
      end
      if (v2_r) begin
        rem_r <= REM_W'(fixed);
      end
    end

    assign done = v3_r;
    assign rem  = rem_r;
  end

endmodule

>>> hw/rtl/gha_checker.sv
`include "generational_handle_allocator_unit_defines.svh"

module gha_checker #(
  parameter int ENTRIES = gha_pkg::ENTRIES_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [gha_pkg::STATUS_W-1:0]    out_status,
  input logic [gha_pkg::OUT_ID_W-1:0]    out_id,
  input logic [gha_pkg::TYPE_W-1:0]      out_type,
  input logic [gha_pkg::INDEX_W-1:0]     out_index,
  input logic [gha_pkg::OBJ_W-1:0]       out_object,
  input logic [gha_pkg::USED_W-1:0]      out_used
);

  localparam int UW = gha_pkg::USED_W;
  localparam logic [UW-1:0] ALL_USED = UW'(ENTRIES);

  // a stalled result keeps its transaction
  `GHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_id) && $stable(out_used) && $stable(out_object), "result changed while stalled")

  // one transaction in flight at a time
  `GHA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "ready right after accept")

  `GHA_ASSERT_SAME(a_no_accept_on_stall, out_valid && !out_ready, !in_ready, "accept with result stalled")

  `GHA_ASSERT_SAME(a_err_zero, out_valid && (out_status != gha_pkg::STAT_OK), (out_type == '0) && (out_index == '0) && (out_object == '0), "payload on error")

  // no free slot only when every slot is taken
  `GHA_ASSERT_SAME(a_no_free_full, out_valid && (out_status == gha_pkg::STAT_NO_FREE), (out_id == '0) && (out_used == ALL_USED), "no free slot but not full")

endmodule

bind generational_handle_allocator_unit gha_checker #(
  .ENTRIES (ENTRIES)
) u_gha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_status (out_rsp.status),
  .out_id     (out_rsp.out_id),
  .out_type   (out_rsp.out_type),
  .out_index  (out_rsp.out_index),
  .out_object (out_rsp.out_object),
  .out_used   (out_rsp.used_count)
);
